### rtl/lri_pkg.sv
// Shared types and constants for the 625-to-512 linear interpolation resampler.
// No dependencies; every other file in rtl/ imports this package.
package lri_pkg;

  // Block geometry. OUT_BLOCK must be a power of two: the weight division is a shift.
  localparam int IN_BLOCK     = 625;
  localparam int OUT_BLOCK    = 512;
  localparam int SAMPLE_WIDTH = 16;

  localparam int FRAC_W = $clog2(OUT_BLOCK);
  // Wide enough for the slot counter and for the base position one step past a block.
  localparam int CNT_W  = $clog2(IN_BLOCK + IN_BLOCK / OUT_BLOCK + 2);
  localparam int STEP_Q = IN_BLOCK / OUT_BLOCK;
  localparam int STEP_R = IN_BLOCK % OUT_BLOCK;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [FRAC_W-1:0]              frac_t;
  typedef logic [CNT_W-1:0]               cnt_t;

  typedef struct packed {
    sample_t sample_i;
    sample_t sample_q;
  } in_beat_t;

  typedef struct packed {
    sample_t out_i;
    sample_t out_q;
  } out_beat_t;

endpackage

### rtl/lri_mix.sv
// Two-point linear interpolation of one real component.
// Depends on lri_pkg for the sample and fraction types.
module lri_mix import lri_pkg::*; (
  input  sample_t cur,
  input  sample_t prev,
  input  frac_t   frac,
  output sample_t mixed
);

  localparam int PW = SAMPLE_WIDTH + FRAC_W + 2;

  logic signed [SAMPLE_WIDTH:0] diff;
  logic signed [FRAC_W:0]       weight;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         sum;

  // f*cur + (N-f)*prev equals N*prev + f*(cur-prev); the floor of the division
  // by N is then prev plus the arithmetic shift of the product.
  assign diff   = $signed({cur[SAMPLE_WIDTH-1], cur}) - $signed({prev[SAMPLE_WIDTH-1], prev});
  assign weight = $signed({1'b0, frac});
  assign prod   = PW'(diff) * PW'(weight);
  assign sum    = PW'(prev) + (prod >>> FRAC_W);
  assign mixed  = sum[SAMPLE_WIDTH-1:0];

endmodule

### rtl/linear_interp_resampler_625_to_512.sv
// Top level of the 625-to-512 linear interpolation resampler for complex samples.
// Depends on lri_pkg and instantiates lri_mix for the I and Q components.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+----------------------------------
//   input   | in_valid, in_stall, in_data    | one complex sample (sample_i/q)
//   result  | out_valid, out_stall, out_data | one interpolated sample (out_i/q)
//
// Input beats are taken one per clock while in_stall is low; a result shows in the
//   cycle after the beat that causes it, held in the output register.
// The rate is set by the single output register: while it holds a result that
//   is stalled, in_stall is raised; otherwise a new beat is taken every clock.
// Reset (rst_n low, synchronous) empties the output register and returns the
//   slot counter and the phase to the start of a block.
// About 512 of every 625 input beats produce a result.
module linear_interp_resampler_625_to_512 import lri_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // Slot counter: the slot the next input sample fills. Slot 0 is only used
  // right after reset; afterwards the last sample of a block serves as slot 0.
  cnt_t      pos_r, pos_nxt;
  // Output phase j*IN_BLOCK split into base sample and fraction.
  cnt_t      base_r, base_nxt;
  frac_t     frac_r, frac_nxt;
  sample_t   prev_i_r, prev_q_r;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;

  logic          in_acc;
  logic          emit;
  logic [FRAC_W:0] frac_sum;
  logic          carry;
  out_beat_t     mixed;

  // The result register is the only buffer: a beat may enter unless it is full
  // and its content is being held back by the consumer.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // An output is due when its left neighbour is the previous sample, that is
  // when the base equals the slot the incoming sample fills minus one.
  assign emit = (pos_r != '0) && (base_r == pos_r - cnt_t'(1));

  // Advancing the phase by IN_BLOCK adds the quotient to the base and the
  // remainder to the fraction, carrying once on overflow.
  assign frac_sum = {1'b0, frac_r} + (FRAC_W + 1)'(STEP_R);
  assign carry    = frac_sum >= (FRAC_W + 1)'(OUT_BLOCK);

  lri_mix u_mix_i (
    .cur   (in_data.sample_i),
    .prev  (prev_i_r),
    .frac  (frac_r),
    .mixed (mixed.out_i)
  );

  lri_mix u_mix_q (
    .cur   (in_data.sample_q),
    .prev  (prev_q_r),
    .frac  (frac_r),
    .mixed (mixed.out_q)
  );

  always_comb begin
    pos_nxt  = pos_r;
    base_nxt = base_r;
    frac_nxt = frac_r;
    if (in_acc) begin
      if (emit) begin
        base_nxt = base_r + cnt_t'(STEP_Q) + cnt_t'(carry);
        frac_nxt = carry ? frac_t'(frac_sum - (FRAC_W + 1)'(OUT_BLOCK)) : frac_t'(frac_sum);
      end
      if (pos_r == '0) begin
        pos_nxt = cnt_t'(1);
      end else if (pos_r >= cnt_t'(IN_BLOCK)) begin
        // The closing sample of a block becomes slot 0 of the next one.
        pos_nxt  = cnt_t'(1);
        base_nxt = '0;
        frac_nxt = '0;
      end else begin
        pos_nxt = pos_r + cnt_t'(1);
      end
    end
  end

  always_comb begin
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      base_r      <= '0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      base_r      <= base_nxt;
      frac_r      <= frac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset: the first beat after reset loads prev
  // before it is ever used, and out_data is only looked at while out_valid.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_i_r <= in_data.sample_i;
      prev_q_r <= in_data.sample_q;
    end
    if (in_acc && emit) begin
      out_data_r <= mixed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled while the result register is empty");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= cnt_t'(IN_BLOCK))
    else $error("slot counter beyond the block length");

  a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, frac_r} < (FRAC_W + 1)'(OUT_BLOCK))
    else $error("phase fraction out of range");

  a_first_fills_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pos_r == '0) |=> (pos_r == cnt_t'(1) && !out_valid_r))
    else $error("first sample after reset produced a result or missed slot 0");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> out_valid_r)
    else $error("due result was not registered");

endmodule
